// ===== rtl/dmabp_pkg.sv =====
// Shared types and constants for the DMA channel burst planner.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package dmabp_pkg;

  // Default values for the top-level parameters.
  localparam int unsigned BOUNDARY_BYTES_DEF = 4096;
  localparam int unsigned MAX_INCR_BEATS_DEF = 256;
  localparam int unsigned COUNT_BITS_DEF     = 22;
  localparam int unsigned ADDR_BITS_DEF      = 64;

  // Fixed field widths.
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned KIND_W   = 3;
  localparam int unsigned WLOG_W   = 3;
  localparam int unsigned BLOG_W   = 4;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned IDX_W    = 3;
  localparam int unsigned BEAT_W   = 9;
  localparam int unsigned BUNIT_W  = 11;
  localparam int unsigned WBYTE_W  = 16;

  // Validation limits.
  localparam logic [BLOG_W-1:0] BURST_LOG_LIMIT = BLOG_W'(11);
  localparam logic [WLOG_W-1:0] WIDTH_LOG_LIMIT = WLOG_W'(6);

  typedef enum logic [ACTION_W-1:0] {
    ACT_START   = 2'd0,
    ACT_ADVANCE = 2'd1,
    ACT_ABORT   = 2'd2
  } action_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_READ    = 3'd0,
    KIND_WRITE   = 3'd1,
    KIND_DONE    = 3'd2,
    KIND_ERROR   = 3'd3,
    KIND_ABORTED = 3'd4
  } kind_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_INCR  = 2'd0,
    MODE_DECR  = 2'd1,
    MODE_FIXED = 2'd2
  } mode_t;

  typedef enum logic [IDX_W-1:0] {
    REG_SRC_ADDR  = 3'd0,
    REG_DST_ADDR  = 3'd1,
    REG_COUNT     = 3'd2,
    REG_SRC_WLOG  = 3'd3,
    REG_DST_WLOG  = 3'd4,
    REG_BURST_LOG = 3'd5,
    REG_SRC_MODE  = 3'd6,
    REG_DST_MODE  = 3'd7
  } reg_idx_t;

endpackage

`default_nettype wire

// ===== rtl/dmabp_in_if.sv =====
// Input channel of the burst planner: valid/ready handshake with the action beat.
// Depends on dmabp_pkg for field widths.
`default_nettype none

interface dmabp_in_if;
  logic                          valid;
  logic                          ready;
  logic [dmabp_pkg::ACTION_W-1:0] action;
  logic                          prior_failed;

  modport source (output valid, output action, output prior_failed, input ready);
  modport sink   (input valid, input action, input prior_failed, output ready);
endinterface

`default_nettype wire

// ===== rtl/dmabp_out_if.sv =====
// Result channel of the burst planner: valid/ready handshake with one command beat.
// Depends on dmabp_pkg for field widths and the kind type.
`default_nettype none

interface dmabp_out_if #(
  parameter int unsigned ADDR_BITS = dmabp_pkg::ADDR_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  dmabp_pkg::kind_t             kind;
  logic [ADDR_BITS-1:0]         first_address;
  logic [ADDR_BITS-1:0]         final_address;
  logic [dmabp_pkg::BEAT_W-1:0] beat_count;
  logic [dmabp_pkg::WLOG_W-1:0] beat_size_log;

  modport source (output valid, output kind, output first_address, output final_address,
                  output beat_count, output beat_size_log, input ready);
  modport sink   (input valid, input kind, input first_address, input final_address,
                  input beat_count, input beat_size_log, output ready);
endinterface

`default_nettype wire

// ===== rtl/dma_channel_axi_burst_planner_unit.sv =====
// Top level of the DMA channel burst planner.
// Depends on dmabp_pkg, dmabp_in_if and dmabp_out_if.
`default_nettype none

// The planner turns one DMA channel transfer into a stream of bus burst
// commands. Program the eight configuration registers while the channel is
// idle, then send a start beat: a transfer that fails its checks (empty, burst
// log of 11 or more, a width log of 6 or more, or misaligned addresses or
// sizes) answers with an error beat, a good one answers with nothing. Every
// advance beat then returns the next command: read bursts covering one DMA
// burst of source units, then the write bursts that store it, and so on until
// a done beat. Incrementing bursts stop at the beat limit and at every
// address boundary; decrementing and fixed modes move single beats. An abort
// beat is remembered and reported as aborted at the next DMA burst boundary,
// and an advance flagged with prior_failed ends the transfer with an error.
// A good start, an abort and an idle advance produce no result beat. Each beat
// passes an input register and then a result register on its way out, and
// the block takes one beat every cycle as long as the result side keeps up;
// the rate is set by the single planning pass (one boundary compare and two
// address adders) between those registers.
module dma_channel_axi_burst_planner_unit #(
  parameter int unsigned BOUNDARY_BYTES = dmabp_pkg::BOUNDARY_BYTES_DEF,
  parameter int unsigned MAX_INCR_BEATS = dmabp_pkg::MAX_INCR_BEATS_DEF,
  parameter int unsigned COUNT_BITS     = dmabp_pkg::COUNT_BITS_DEF,
  parameter int unsigned ADDR_BITS      = dmabp_pkg::ADDR_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [dmabp_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [ADDR_BITS-1:0]          cfg_data,
  dmabp_in_if.sink                           in_if,
  dmabp_out_if.source                        out_if
);

  // Boundary offset width and a common width for the length compare.
  localparam int unsigned BND_W = $clog2(BOUNDARY_BYTES);
  localparam int unsigned CMP_W = (BND_W + 1 > dmabp_pkg::WBYTE_W) ?
                                  BND_W + 1 : dmabp_pkg::WBYTE_W;
  localparam int unsigned UL_W  = (COUNT_BITS > dmabp_pkg::BUNIT_W) ?
                                  COUNT_BITS : dmabp_pkg::BUNIT_W;
  localparam logic [BND_W:0]                 BND_VAL  = (BND_W+1)'(BOUNDARY_BYTES);
  localparam logic [dmabp_pkg::BEAT_W-1:0]   MAX_BEAT = dmabp_pkg::BEAT_W'(MAX_INCR_BEATS);

  // ---------------------------------------------------------------------
  // Configuration registers. Writes are dropped while a transfer runs.
  // ---------------------------------------------------------------------
  logic [ADDR_BITS-1:0]          src_addr_r, dst_addr_r;
  logic [COUNT_BITS-1:0]         count_r;
  logic [dmabp_pkg::WLOG_W-1:0]  src_wlog_r, dst_wlog_r;
  logic [dmabp_pkg::BLOG_W-1:0]  burst_log_r;
  logic [dmabp_pkg::MODE_W-1:0]  src_mode_r, dst_mode_r;

  // Channel state.
  logic                          running_r, running_nxt;
  logic                          wr_phase_r, wr_phase_nxt;
  logic                          abort_pend_r, abort_pend_nxt;
  logic [ADDR_BITS-1:0]          cur_src_r, cur_src_nxt;
  logic [ADDR_BITS-1:0]          cur_dst_r, cur_dst_nxt;
  logic [COUNT_BITS-1:0]         units_left_r, units_left_nxt;
  logic [dmabp_pkg::BUNIT_W-1:0] burst_left_r, burst_left_nxt;
  logic [dmabp_pkg::WBYTE_W-1:0] wr_bytes_r, wr_bytes_nxt;

  // Input register stage.
  logic                          s1_valid_r, s1_valid_nxt;
  dmabp_pkg::action_t            s1_action_r;
  logic                          s1_failed_r;
  logic                          s1_fire;

  // Result register stage.
  logic                          out_valid_r, out_valid_nxt;
  dmabp_pkg::kind_t              out_kind_r, out_kind_nxt;
  logic [ADDR_BITS-1:0]          out_first_r, out_first_nxt;
  logic [ADDR_BITS-1:0]          out_final_r, out_final_nxt;
  logic [dmabp_pkg::BEAT_W-1:0]  out_beats_r, out_beats_nxt;
  logic [dmabp_pkg::WLOG_W-1:0]  out_size_r, out_size_nxt;
  logic                          emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_addr_r  <= '0;
      dst_addr_r  <= '0;
      count_r     <= '0;
      src_wlog_r  <= '0;
      dst_wlog_r  <= '0;
      burst_log_r <= '0;
      src_mode_r  <= '0;
      dst_mode_r  <= '0;
    end else if (cfg_we && !running_r) begin
      unique case (dmabp_pkg::reg_idx_t'(cfg_index))
        dmabp_pkg::REG_SRC_ADDR:  src_addr_r  <= cfg_data;
        dmabp_pkg::REG_DST_ADDR:  dst_addr_r  <= cfg_data;
        dmabp_pkg::REG_COUNT:     count_r     <= cfg_data[COUNT_BITS-1:0];
        dmabp_pkg::REG_SRC_WLOG:  src_wlog_r  <= cfg_data[dmabp_pkg::WLOG_W-1:0];
        dmabp_pkg::REG_DST_WLOG:  dst_wlog_r  <= cfg_data[dmabp_pkg::WLOG_W-1:0];
        dmabp_pkg::REG_BURST_LOG: burst_log_r <= cfg_data[dmabp_pkg::BLOG_W-1:0];
        dmabp_pkg::REG_SRC_MODE:  src_mode_r  <= cfg_data[dmabp_pkg::MODE_W-1:0];
        dmabp_pkg::REG_DST_MODE:  dst_mode_r  <= cfg_data[dmabp_pkg::MODE_W-1:0];
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Handshakes. The input register drains whenever the result register is
  // free or being emptied, so one beat moves through every cycle.
  // ---------------------------------------------------------------------
  assign s1_fire      = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready  = !s1_valid_r || s1_fire;
  assign s1_valid_nxt = (in_if.valid && in_if.ready) || (s1_valid_r && !s1_fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      s1_action_r <= dmabp_pkg::action_t'(in_if.action);
      s1_failed_r <= in_if.prior_failed;
    end
  end

  // ---------------------------------------------------------------------
  // Start checks. Only the low six bits matter for alignment because both
  // widths are below 64 bytes once the range checks pass.
  // ---------------------------------------------------------------------
  logic       cfg_ok;
  logic [5:0] src_mask, dst_mask, total_low;
  logic [4:0] bb_log;

  always_comb begin
    src_mask  = (6'd1 << src_wlog_r) - 6'd1;
    dst_mask  = (6'd1 << dst_wlog_r) - 6'd1;
    total_low = count_r[5:0] << src_wlog_r;
    bb_log    = 5'(burst_log_r) + 5'(src_wlog_r);
    cfg_ok    = (count_r != '0) && (burst_log_r < dmabp_pkg::BURST_LOG_LIMIT) &&
                (src_wlog_r < dmabp_pkg::WIDTH_LOG_LIMIT) &&
                (dst_wlog_r < dmabp_pkg::WIDTH_LOG_LIMIT) &&
                ((src_addr_r[5:0] & src_mask) == 6'd0) &&
                ((dst_addr_r[5:0] & dst_mask) == 6'd0) &&
                ((total_low & dst_mask) == 6'd0) &&
                (bb_log >= 5'(dst_wlog_r));
  end

  // ---------------------------------------------------------------------
  // Burst sizing for the read side: a new DMA burst takes the smaller of
  // the remaining units and 2^burst_log.
  // ---------------------------------------------------------------------
  logic [dmabp_pkg::BUNIT_W-1:0] burst_units;
  logic [dmabp_pkg::BUNIT_W-1:0] burst_eff;
  logic [dmabp_pkg::WBYTE_W-1:0] burst_bytes;

  always_comb begin
    burst_units = dmabp_pkg::BUNIT_W'(1) << burst_log_r;
    if (burst_left_r != '0) begin
      burst_eff = burst_left_r;
    end else if (UL_W'(units_left_r) < UL_W'(burst_units)) begin
      burst_eff = dmabp_pkg::BUNIT_W'(units_left_r);
    end else begin
      burst_eff = burst_units;
    end
    burst_bytes = dmabp_pkg::WBYTE_W'(burst_eff) << src_wlog_r;
  end

  // ---------------------------------------------------------------------
  // Single planner shared by both phases: picks the cursor of the active side,
  // clips an incrementing burst at the beat limit and at the next boundary,
  // moves one beat in other modes, forms the last address and advanced cursor.
  // ---------------------------------------------------------------------
  logic [ADDR_BITS-1:0]          pl_start, pl_span, pl_final, pl_next;
  dmabp_pkg::mode_t              pl_mode;
  logic [dmabp_pkg::WLOG_W-1:0]  pl_wlog;
  logic [dmabp_pkg::WBYTE_W-1:0] pl_want;
  logic [dmabp_pkg::BEAT_W-1:0]  want_clip, pl_len;
  logic [BND_W:0]                to_bound, beats_to_bound;
  logic [dmabp_pkg::WBYTE_W-1:0] wr_used;

  always_comb begin
    if (wr_phase_r) begin
      pl_start = cur_dst_r;
      pl_mode  = dmabp_pkg::mode_t'(dst_mode_r);
      pl_wlog  = dst_wlog_r;
      pl_want  = wr_bytes_r >> dst_wlog_r;
    end else begin
      pl_start = cur_src_r;
      pl_mode  = dmabp_pkg::mode_t'(src_mode_r);
      pl_wlog  = src_wlog_r;
      pl_want  = dmabp_pkg::WBYTE_W'(burst_eff);
    end

    want_clip      = (pl_want > dmabp_pkg::WBYTE_W'(MAX_BEAT)) ? MAX_BEAT :
                     pl_want[dmabp_pkg::BEAT_W-1:0];
    to_bound       = BND_VAL - {1'b0, pl_start[BND_W-1:0]};
    beats_to_bound = to_bound >> pl_wlog;

    if (pl_mode == dmabp_pkg::MODE_INCR) begin
      if (CMP_W'(beats_to_bound) < CMP_W'(want_clip)) begin
        pl_len = dmabp_pkg::BEAT_W'(beats_to_bound);
      end else begin
        pl_len = want_clip;
      end
      if (pl_len == '0) begin
        pl_len = dmabp_pkg::BEAT_W'(1);
      end
    end else begin
      pl_len = dmabp_pkg::BEAT_W'(1);
    end

    pl_span  = ADDR_BITS'(pl_len) << pl_wlog;
    pl_final = pl_start + pl_span - ADDR_BITS'(1);
    case (pl_mode)
      dmabp_pkg::MODE_INCR: pl_next = pl_start + pl_span;
      dmabp_pkg::MODE_DECR: pl_next = pl_start - (ADDR_BITS'(1) << pl_wlog);
      default:              pl_next = pl_start;
    endcase

    wr_used = dmabp_pkg::WBYTE_W'(pl_len) << dst_wlog_r;
  end

  // ---------------------------------------------------------------------
  // Channel sequencing for the beat in the input register.
  // ---------------------------------------------------------------------
  always_comb begin
    running_nxt    = running_r;
    wr_phase_nxt   = wr_phase_r;
    abort_pend_nxt = abort_pend_r;
    cur_src_nxt    = cur_src_r;
    cur_dst_nxt    = cur_dst_r;
    units_left_nxt = units_left_r;
    burst_left_nxt = burst_left_r;
    wr_bytes_nxt   = wr_bytes_r;
    emit           = 1'b0;
    out_kind_nxt   = dmabp_pkg::KIND_DONE;
    out_first_nxt  = '0;
    out_final_nxt  = '0;
    out_beats_nxt  = '0;
    out_size_nxt   = '0;

    if (s1_fire) begin
      unique case (s1_action_r)
        dmabp_pkg::ACT_START: begin
          wr_phase_nxt   = 1'b0;
          abort_pend_nxt = 1'b0;
          burst_left_nxt = '0;
          wr_bytes_nxt   = '0;
          if (cfg_ok) begin
            running_nxt    = 1'b1;
            cur_src_nxt    = src_addr_r;
            cur_dst_nxt    = dst_addr_r;
            units_left_nxt = count_r;
          end else begin
            running_nxt  = 1'b0;
            emit         = 1'b1;
            out_kind_nxt = dmabp_pkg::KIND_ERROR;
          end
        end
        dmabp_pkg::ACT_ABORT: begin
          if (running_r) begin
            abort_pend_nxt = 1'b1;
          end
        end
        dmabp_pkg::ACT_ADVANCE: begin
          if (running_r) begin
            emit = 1'b1;
            if (s1_failed_r || (!wr_phase_r && burst_left_r == '0 &&
                                (units_left_r == '0 || abort_pend_r))) begin
              // The transfer ends: failure, completion or a pending abort.
              running_nxt    = 1'b0;
              wr_phase_nxt   = 1'b0;
              abort_pend_nxt = 1'b0;
              burst_left_nxt = '0;
              wr_bytes_nxt   = '0;
              if (s1_failed_r) begin
                out_kind_nxt = dmabp_pkg::KIND_ERROR;
              end else if (units_left_r == '0) begin
                out_kind_nxt = dmabp_pkg::KIND_DONE;
              end else begin
                out_kind_nxt = dmabp_pkg::KIND_ABORTED;
              end
            end else begin
              out_first_nxt = pl_start;
              out_final_nxt = pl_final;
              out_beats_nxt = pl_len;
              out_size_nxt  = pl_wlog;
              if (wr_phase_r) begin
                out_kind_nxt = dmabp_pkg::KIND_WRITE;
                cur_dst_nxt  = pl_next;
                wr_bytes_nxt = (wr_used >= wr_bytes_r) ? '0 : wr_bytes_r - wr_used;
                wr_phase_nxt = (wr_used < wr_bytes_r);
              end else begin
                out_kind_nxt   = dmabp_pkg::KIND_READ;
                cur_src_nxt    = pl_next;
                burst_left_nxt = burst_eff - dmabp_pkg::BUNIT_W'(pl_len);
                units_left_nxt = COUNT_BITS'(UL_W'(units_left_r) - UL_W'(pl_len));
                wr_phase_nxt   = (burst_eff == dmabp_pkg::BUNIT_W'(pl_len));
                if (burst_left_r == '0) begin
                  wr_bytes_nxt = burst_bytes;
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r    <= 1'b0;
      wr_phase_r   <= 1'b0;
      abort_pend_r <= 1'b0;
      cur_src_r    <= '0;
      cur_dst_r    <= '0;
      units_left_r <= '0;
      burst_left_r <= '0;
      wr_bytes_r   <= '0;
    end else begin
      running_r    <= running_nxt;
      wr_phase_r   <= wr_phase_nxt;
      abort_pend_r <= abort_pend_nxt;
      cur_src_r    <= cur_src_nxt;
      cur_dst_r    <= cur_dst_nxt;
      units_left_r <= units_left_nxt;
      burst_left_r <= burst_left_nxt;
      wr_bytes_r   <= wr_bytes_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------
  assign out_valid_nxt = emit || (out_valid_r && !out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r  <= out_kind_nxt;
      out_first_r <= out_first_nxt;
      out_final_r <= out_final_nxt;
      out_beats_r <= out_beats_nxt;
      out_size_r  <= out_size_nxt;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.kind          = out_kind_r;
  assign out_if.first_address = out_first_r;
  assign out_if.final_address = out_final_r;
  assign out_if.beat_count    = out_beats_r;
  assign out_if.beat_size_log = out_size_r;

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !running_r |-> (!wr_phase_r && !abort_pend_r && burst_left_r == '0))
    else $error("idle channel holds burst state");

  a_write_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    wr_phase_r |-> (wr_bytes_r != '0))
    else $error("write phase with no bytes left");

  a_burst_beats: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_kind_r == dmabp_pkg::KIND_READ ||
                     out_kind_r == dmabp_pkg::KIND_WRITE))
    |-> (out_beats_r != '0 && out_beats_r <= MAX_BEAT))
    else $error("burst beat count out of range");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r != dmabp_pkg::KIND_READ &&
     out_kind_r != dmabp_pkg::KIND_WRITE)
    |-> (out_first_r == '0 && out_final_r == '0 && out_beats_r == '0))
    else $error("status beat carries burst fields");

  a_read_consumes: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && emit && out_kind_nxt == dmabp_pkg::KIND_READ)
    |=> (units_left_r < $past(units_left_r)))
    else $error("read burst did not consume units");

endmodule

`default_nettype wire

// ===== tb/sv/dma_channel_axi_burst_planner_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the DMA channel burst planner top level.
// Uses dmabp_pkg, dmabp_in_if, dmabp_out_if and dma_channel_axi_burst_planner_unit.

module dma_channel_axi_burst_planner_unit_tb;
  import dmabp_pkg::*;

  // Codes that the package leaves unnamed: the spare action and the spare mode.
  localparam logic [ACTION_W-1:0] ACT_SPARE  = 2'd3;
  localparam logic [MODE_W-1:0]   MODE_SPARE = 2'd3;

  localparam int unsigned PAGE_BYTES     = BOUNDARY_BYTES_DEF;
  localparam int unsigned MAX_BEATS      = MAX_INCR_BEATS_DEF;
  localparam int unsigned TARGET_BEATS   = 1950;
  // Settling time that lets any beat still in flight leave the block.
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned QUIET_LIMIT    = 4000;

  // One planned bus command as the result channel shows it.
  typedef struct {
    kind_t    kind;
    bit [63:0] first_addr;
    bit [63:0] last_addr;
    bit [8:0]  beats;
    bit [2:0]  size_log;
  } bus_cmd_t;

  // Burst planner scoreboard: a private copy of the channel registers and state,
  // the queue of commands the block still owes, and the mismatch bookkeeping.
  class burst_plan_board;
    bit [63:0] src_base, dst_base;
    bit [21:0] unit_count;
    bit [2:0]  src_wlog, dst_wlog;
    bit [3:0]  blk_log;
    bit [1:0]  src_mode, dst_mode;

    bit        running, writing, abort_req;
    bit [63:0] src_cur, dst_cur, units_left, blk_units_left, wr_bytes_left;

    bus_cmd_t  owed_cmds[$];
    int unsigned fails, reported;

    function int unsigned pending();
      return owed_cmds.size();
    endfunction

    // Register writes are locked out while a transfer is running.
    function void note_config(reg_idx_t idx, bit [63:0] val);
      if (running) return;
      case (idx)
        REG_SRC_ADDR:  src_base   = val;
        REG_DST_ADDR:  dst_base   = val;
        REG_COUNT:     unit_count = val[21:0];
        REG_SRC_WLOG:  src_wlog   = val[2:0];
        REG_DST_WLOG:  dst_wlog   = val[2:0];
        REG_BURST_LOG: blk_log    = val[3:0];
        REG_SRC_MODE:  src_mode   = val[1:0];
        REG_DST_MODE:  dst_mode   = val[1:0];
        default: ;
      endcase
    endfunction

    function void push_cmd(kind_t k, bit [63:0] f, bit [63:0] l, bit [63:0] n,
                           bit [2:0] wl);
      owed_cmds.push_back('{k, f, l, n[8:0], wl});
    endfunction

    function void close_out(kind_t k);
      running        = 0;
      writing        = 0;
      abort_req      = 0;
      blk_units_left = 0;
      wr_bytes_left  = 0;
      push_cmd(k, 64'd0, 64'd0, 64'd0, 3'd0);
    endfunction

    // One bus burst at the cursor; incrementing bursts stop at the beat limit and
    // at the next page boundary, the other modes move a single beat.
    function bit [63:0] plan_beats(inout bit [63:0] cur, input bit [1:0] mode,
                                   input bit [2:0] wlog, input bit [63:0] want,
                                   output bit [63:0] f, output bit [63:0] l);
      bit [63:0] bytes, room, n;
      bytes = 64'd1 << wlog;
      n     = 64'd1;
      f     = cur;
      if (mode == MODE_INCR) begin
        room = (64'(PAGE_BYTES) - (cur & 64'(PAGE_BYTES - 1))) >> wlog;
        n = want;
        if (n > 64'(MAX_BEATS)) n = 64'(MAX_BEATS);
        if (n > room) n = room;
        if (n == 0) n = 64'd1;
        cur = cur + n * bytes;
      end else if (mode == MODE_DECR) begin
        cur = cur - bytes;
      end
      l = f + n * bytes - 64'd1;
      return n;
    endfunction

    function void start_transfer();
      bit [63:0] smask, dmask, total, blk_bytes;
      bit ok;
      ok = unit_count != 0 && blk_log < BURST_LOG_LIMIT &&
           src_wlog < WIDTH_LOG_LIMIT && dst_wlog < WIDTH_LOG_LIMIT;
      if (ok) begin
        smask     = (64'd1 << src_wlog) - 64'd1;
        dmask     = (64'd1 << dst_wlog) - 64'd1;
        total     = 64'(unit_count) << src_wlog;
        blk_bytes = 64'd1 << (int'(blk_log) + int'(src_wlog));
        ok = (src_base & smask) == 0 && (dst_base & dmask) == 0 &&
             (total & dmask) == 0 && (blk_bytes & dmask) == 0;
      end
      if (!ok) begin
        close_out(KIND_ERROR);
        return;
      end
      running        = 1;
      writing        = 0;
      abort_req      = 0;
      src_cur        = src_base;
      dst_cur        = dst_base;
      units_left     = 64'(unit_count);
      blk_units_left = 0;
      wr_bytes_left  = 0;
    endfunction

    function void advance(bit failed);
      bit [63:0] f, l, n, used, blk;
      if (failed) begin
        close_out(KIND_ERROR);
        return;
      end
      if (writing) begin
        n = plan_beats(dst_cur, dst_mode, dst_wlog, wr_bytes_left >> dst_wlog, f, l);
        used = n << dst_wlog;
        wr_bytes_left = (used >= wr_bytes_left) ? 64'd0 : wr_bytes_left - used;
        if (wr_bytes_left == 0) writing = 0;
        push_cmd(KIND_WRITE, f, l, n, dst_wlog);
        return;
      end
      if (blk_units_left == 0) begin
        // Done takes precedence over a pending abort.
        if (units_left == 0) begin
          close_out(KIND_DONE);
          return;
        end
        if (abort_req) begin
          close_out(KIND_ABORTED);
          return;
        end
        blk = 64'd1 << blk_log;
        blk_units_left = (units_left < blk) ? units_left : blk;
        wr_bytes_left  = (blk_units_left << src_wlog) & 64'hFFFF;
      end
      n = plan_beats(src_cur, src_mode, src_wlog, blk_units_left, f, l);
      blk_units_left = blk_units_left - n;
      units_left     = units_left - n;
      if (blk_units_left == 0) writing = 1;
      push_cmd(KIND_READ, f, l, n, src_wlog);
    endfunction

    // Returns 1 when the beat has an effect on the channel.
    function bit note_beat(bit [1:0] act, bit failed);
      bit took;
      took = 0;
      case (act)
        ACT_START: begin
          start_transfer();
          took = 1;
        end
        ACT_ABORT: begin
          took = running;
          if (running) abort_req = 1;
        end
        ACT_ADVANCE: begin
          took = running;
          if (running) advance(failed);
        end
        default: ;
      endcase
      return took;
    endfunction

    function void check_cmd(logic [2:0] kind, logic [63:0] f, logic [63:0] l,
                            logic [8:0] beats, logic [2:0] wl);
      bus_cmd_t want;
      if (owed_cmds.size() == 0) begin
        fails++;
        if (reported < 10) begin
          reported++;
          $display("unexpected result: kind %0d first %h last %h beats %0d size %0d",
                   kind, f, l, beats, wl);
        end
        return;
      end
      want = owed_cmds.pop_front();
      if (kind !== want.kind || f !== want.first_addr || l !== want.last_addr ||
          beats !== want.beats || wl !== want.size_log) begin
        fails++;
        if (reported < 10) begin
          reported++;
          $display("mismatch: expected kind %0d first %h last %h beats %0d size %0d",
                   want.kind, want.first_addr, want.last_addr, want.beats, want.size_log);
          $display("          got      kind %0d first %h last %h beats %0d size %0d",
                   kind, f, l, beats, wl);
        end
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [IDX_W-1:0]     cfg_index;
  logic [63:0]          cfg_data;
  logic                 rx_ready = 1'b0;

  dmabp_in_if  in_ch ();
  dmabp_out_if #(.ADDR_BITS(64)) out_ch ();

  assign out_ch.ready = rx_ready;

  dma_channel_axi_burst_planner_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_if     (in_ch),
    .out_if    (out_ch)
  );

  burst_plan_board board = new();

  int unsigned beats_done;     // beats that had an effect on the channel
  int unsigned tx_burst_left;  // beats left in the current sender burst
  int unsigned quiet_cycles;
  int unsigned rx_phase_left;
  int unsigned rx_style;
  int unsigned rx_hold;
  logic        rx_level = 1'b0;

  always #5 clk = ~clk;

  // The result side switches at random between four styles: always
  // ready, mostly ready, mostly stalled, and long alternating stall windows.
  always @(posedge clk) begin
    if (rx_phase_left == 0) begin
      rx_style      = $urandom_range(0, 3);
      rx_phase_left = $urandom_range(20, 300);
    end
    rx_phase_left--;
    case (rx_style)
      0: rx_ready <= 1'b1;
      1: rx_ready <= ($urandom_range(0, 3) != 0);
      2: rx_ready <= ($urandom_range(0, 3) == 0);
      default: begin
        if (rx_hold == 0) begin
          rx_hold  = $urandom_range(1, 24);
          rx_level = ~rx_level;
        end
        rx_hold--;
        rx_ready <= rx_level;
      end
    endcase
  end

  // Result checking and the watchdog. Both channels are sampled at the rising
  // edge, before any of this edge's updates land, so the order of processes
  // within the time step does not matter.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      board.check_cmd(out_ch.kind, out_ch.first_address, out_ch.final_address,
                      out_ch.beat_count, out_ch.beat_size_log);
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic bit [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Addresses lean toward the spots that matter: just below a page boundary,
  // just below the top of the address space, and just above zero.
  function automatic bit [63:0] pick_addr(bit [2:0] wlog);
    bit [63:0]   a;
    int unsigned style;
    a     = rand64();
    style = $urandom_range(0, 9);
    if (style < 3)
      a = {a[63:12], 12'h000} - (64'($urandom_range(1, 8)) << wlog);
    else if (style == 3)
      a = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 300));
    else if (style == 4)
      a = 64'($urandom_range(0, 64));
    return a & ~((64'd1 << wlog) - 64'd1);
  endfunction

  function automatic bit [1:0] pick_mode();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return MODE_INCR;
    if (r < 7) return MODE_DECR;
    if (r < 9) return MODE_FIXED;
    return MODE_SPARE;
  endfunction

  // Sends one beat and returns at the edge that accepted it, with valid still
  // high so that a following beat can go out back to back. Bursts of beats are
  // separated by random gaps; about a quarter of the bursts follow with no gap.
  task automatic send_beat(input logic [ACTION_W-1:0] act, input logic failed);
    int unsigned gap;
    if (tx_burst_left == 0) begin
      tx_burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    tx_burst_left--;
    in_ch.valid        <= 1'b1;
    in_ch.action       <= act;
    in_ch.prior_failed <= failed;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (board.note_beat(act, failed)) beats_done++;
  endtask

  // Holds the sender off until every owed command has come back, then lets the
  // pipeline settle so that beats without a result have also left the block.
  task automatic wait_idle();
    in_ch.valid  <= 1'b0;
    tx_burst_left = 0;
    do @(posedge clk); while (board.pending() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    board.note_config(idx, val);
  endtask

  task automatic program_regs(input bit [63:0] sa, input bit [63:0] da,
                              input bit [21:0] cnt, input bit [2:0] sw,
                              input bit [2:0] dw, input bit [3:0] bl,
                              input bit [1:0] sm, input bit [1:0] dm);
    cfg_write(REG_SRC_ADDR, sa);
    cfg_write(REG_DST_ADDR, da);
    cfg_write(REG_COUNT, 64'(cnt));
    cfg_write(REG_SRC_WLOG, 64'(sw));
    cfg_write(REG_DST_WLOG, 64'(dw));
    cfg_write(REG_BURST_LOG, 64'(bl));
    cfg_write(REG_SRC_MODE, 64'(sm));
    cfg_write(REG_DST_MODE, 64'(dm));
    cfg_we <= 1'b0;
  endtask

  // Most settings are legal transfers; the count is kept a multiple of the
  // destination width so the total stays aligned, and non-incrementing modes
  // get short DMA bursts since every unit costs an advance there. The rest are
  // fully random settings or a legal one with a single field broken.
  task automatic program_random();
    bit [63:0]   sa, da;
    bit [21:0]   cnt;
    bit [2:0]    sw, dw;
    bit [3:0]    bl;
    bit [1:0]    sm, dm;
    int unsigned unit_log, r, r2;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      sa  = rand64();
      da  = rand64();
      cnt = ($urandom_range(0, 3) == 0) ? 22'd0 : 22'($urandom);
      sw  = 3'($urandom_range(0, 7));
      dw  = 3'($urandom_range(0, 7));
      bl  = 4'($urandom_range(0, 15));
      sm  = 2'($urandom_range(0, 3));
      dm  = 2'($urandom_range(0, 3));
    end else begin
      sw       = 3'($urandom_range(0, 5));
      dw       = 3'($urandom_range(0, 5));
      unit_log = (dw > sw) ? dw - sw : 0;
      sm       = pick_mode();
      dm       = pick_mode();
      if (sm == MODE_INCR && dm == MODE_INCR && $urandom_range(0, 3) == 0)
        bl = 4'($urandom_range(unit_log, 10));
      else
        bl = 4'(unit_log + $urandom_range(0, 2));
      r2 = $urandom_range(0, 19);
      if (r2 < 14)
        cnt = 22'($urandom_range(1, 8) << unit_log);
      else if (r2 < 19)
        cnt = 22'($urandom_range(9, 200) << unit_log);
      else
        cnt = 22'($urandom) & ~22'((1 << unit_log) - 1);
      if (cnt == 0) cnt = 22'(1 << unit_log);
      sa = pick_addr(sw);
      da = pick_addr(dw);
      if (r < 25) begin
        case ($urandom_range(0, 7))
          0: sa = sa | 64'd1;
          1: da = da | 64'd1;
          2: cnt = cnt + 22'd1;
          3: cnt = 22'd0;
          4: bl = 4'($urandom_range(11, 15));
          5: sw = 3'($urandom_range(6, 7));
          6: dw = 3'($urandom_range(6, 7));
          default: if (dw > sw) bl = 4'd0;  // DMA burst smaller than one write beat
        endcase
      end
    end
    program_regs(sa, da, cnt, sw, dw, bl, sm, dm);
  endtask

  // One transfer: a start, then mostly plain advances with the odd abort,
  // restart, failed command or spare action mixed in. A transfer that runs past
  // its budget is either aborted or ended by a failed command.
  task automatic run_transfer();
    int unsigned budget, r;
    if ($urandom_range(0, 9) == 0)
      send_beat(2'($urandom_range(1, 3)), 1'($urandom_range(0, 1)));
    send_beat(ACT_START, 1'($urandom_range(0, 1)));
    budget = $urandom_range(4, 120);
    while (board.running && budget > 0) begin
      r = $urandom_range(0, 199);
      if (r < 6)
        send_beat(ACT_ABORT, 1'($urandom_range(0, 1)));
      else if (r < 8)
        send_beat(ACT_SPARE, 1'($urandom_range(0, 1)));
      else if (r < 10)
        send_beat(ACT_ADVANCE, 1'b1);
      else if (r < 12)
        send_beat(ACT_START, 1'b0);
      else if (r < 14) begin
        // Registers written in mid transfer must be ignored.
        wait_idle();
        program_random();
      end else
        send_beat(ACT_ADVANCE, 1'b0);
      budget--;
    end
    if (board.running && $urandom_range(0, 1) == 1) begin
      send_beat(ACT_ABORT, 1'b0);
      budget = 80;
      while (board.running && budget > 0) begin
        send_beat(ACT_ADVANCE, 1'b0);
        budget--;
      end
    end
    if (board.running) send_beat(ACT_ADVANCE, 1'b1);
  endtask

  initial begin
    in_ch.valid        <= 1'b0;
    in_ch.action       <= ACT_START;
    in_ch.prior_failed <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= REG_SRC_ADDR;
    cfg_data           <= 64'd0;
    rst_n              <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Out of reset every register is zero: beats to an idle channel are
    // ignored, and starting an empty transfer is an error.
    send_beat(ACT_ADVANCE, 1'b0);
    send_beat(ACT_ABORT, 1'b1);
    send_beat(ACT_SPARE, 1'b1);
    send_beat(ACT_START, 1'b0);

    // Source reads straddle a page boundary and the first write ends right at
    // one. The abort lands in the write phase and is reported only once the
    // DMA burst is fully written.
    wait_idle();
    program_regs(64'h0FE0, 64'h1_0FFC, 22'd16, 3'd3, 3'd2, 4'd3, MODE_INCR, MODE_INCR);
    send_beat(ACT_START, 1'b0);
    send_beat(ACT_ADVANCE, 1'b0);
    send_beat(ACT_ADVANCE, 1'b0);
    send_beat(ACT_ADVANCE, 1'b0);
    send_beat(ACT_ABORT, 1'b0);
    send_beat(ACT_ADVANCE, 1'b0);
    send_beat(ACT_ADVANCE, 1'b0);

    // Restart, then try to reprogram while running (ignored), then end the
    // transfer with a failed command.
    send_beat(ACT_START, 1'b0);
    send_beat(ACT_ADVANCE, 1'b0);
    wait_idle();
    program_regs(64'h40, 64'h80, 22'd1, 3'd0, 3'd0, 4'd0, MODE_FIXED, MODE_FIXED);
    send_beat(ACT_ADVANCE, 1'b0);
    send_beat(ACT_ADVANCE, 1'b1);

    // Largest legal transfer: reads start at the top of the address space and
    // wrap to zero, with the widest beats and the longest DMA burst.
    wait_idle();
    program_regs(64'hFFFF_FFFF_FFFF_FFE0, 64'd0, 22'h3FFFFF, 3'd5, 3'd5, 4'd10,
                 MODE_INCR, MODE_DECR);
    send_beat(ACT_START, 1'b0);
    send_beat(ACT_ADVANCE, 1'b0);
    send_beat(ACT_ADVANCE, 1'b0);
    send_beat(ACT_ADVANCE, 1'b1);

    // Fields at or near their top values: rejected.
    wait_idle();
    program_regs(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 22'h3FFFFF,
                 3'd7, 3'd6, 4'd15, MODE_SPARE, MODE_FIXED);
    send_beat(ACT_START, 1'b0);

    // The spare mode behaves as fixed; writes are twice the read width.
    wait_idle();
    program_regs(64'h1, 64'h2, 22'd4, 3'd0, 3'd1, 4'd1, MODE_SPARE, MODE_FIXED);
    send_beat(ACT_START, 1'b0);
    send_beat(ACT_ADVANCE, 1'b0);
    send_beat(ACT_ADVANCE, 1'b0);
    send_beat(ACT_ADVANCE, 1'b0);
    send_beat(ACT_ADVANCE, 1'b0);

    // Random transfers. Most get fresh settings after the channel drains; a
    // few simply start again with the settings they have.
    while (beats_done < TARGET_BEATS) begin
      if ($urandom_range(0, 9) != 0) begin
        wait_idle();
        program_random();
      end
      run_transfer();
    end

    wait_idle();
    if (board.fails == 0 && board.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
